>>> rtl/core/elr_pkg.sv
// ---------------------------------------------------------------------------
// Event log ring package
// Shared constants, record type and opcode codes for the event log ring.
// ---------------------------------------------------------------------------
package elr_pkg;

   localparam int unsigned Capacity = 128;
   localparam int unsigned PtrW     = $clog2(Capacity);
   localparam int unsigned FillW    = $clog2(Capacity + 1);
   localparam int unsigned RecW     = 64 + 32 + 8 + 2 + 64;

   typedef enum logic [2:0] {
      OP_REPORT   = 3'd0,
      OP_POP      = 3'd1,
      OP_CLR_LAT  = 3'd2,
      OP_STATS    = 3'd3,
      OP_FIRST    = 3'd4,
      OP_LAST     = 3'd5,
      OP_CLR_ALL  = 3'd6,
      OP_BAD      = 3'd7
   } opcode_type;

   typedef struct packed {
      logic [63:0] args;
      logic [1:0]  nargs;
      logic [7:0]  sev;
      logic [31:0] ident;
      logic [63:0] time_stamp;
   } record_type;

   // saturating increment
   function automatic logic [31:0] sat_inc(input logic [31:0] v);
      sat_inc = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
   endfunction

endpackage

>>> rtl/core/elr_ram.sv
// ---------------------------------------------------------------------------
// Generic simple dual port RAM
// One write port and one read port, registered read data.
// ---------------------------------------------------------------------------
module elr_ram #(
   parameter int unsigned Width = 8,
   parameter int unsigned Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];

   // storage and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

>>> rtl/core/event_log_ring_priority_evict_unit.sv
// ---------------------------------------------------------------------------
// Event log ring with priority eviction
// FIFO ring of event records; when full it evicts the oldest non-critical record.
// ---------------------------------------------------------------------------
// One beat at a time goes through a small sequencer around the record RAM.
// Commands other than report and pop go from accept through the execute
// state to the result. A pop adds one RAM read with registered data, and a
// report into a ring that is not full adds one write. A report into a full
// ring scans the severities oldest first, one RAM read a cycle, and once a
// non-critical record is found closes the gap by moving each later record
// down one slot, one read and one write a cycle. Scan and move share one
// pass over the ring. If no record is non-critical, a critical beat evicts
// the oldest record and any other beat is dropped. req_tready is low while
// a beat is at work or its result waits on rsp.
module event_log_ring_priority_evict_unit
   import elr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic [7:0]   csr_wr_data,
   input  logic         req_tvalid,
   output logic         req_tready,
   // opcode[2:0], timestamp[66:3], event_id[98:67], severity[106:99],
   // arg_count[114:107], arguments[178:115], args_present[179], zero pad
   input  logic [183:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status[0], out_timestamp[64:1], out_id[96:65], out_severity[104:97],
   // out_arg_count[106:105], out_arguments[170:107], published_total[202:171],
   // consumed_total[234:203], overflow_total[266:235], dropped_total[298:267],
   // occupancy[306:299], critical_total[338:307], zero pad
   output logic [343:0] rsp_tdata
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_EXEC, ST_SCAN, ST_MOVE, ST_POPRD, ST_WRITE, ST_RESP
   } state_type;

   state_type       state_ff;
   logic [7:0]      crit_code_ff;
   logic [PtrW-1:0] head_ff;
   logic [FillW-1:0] fill_ff;
   logic [31:0]     pub_ff, con_ff, ovf_ff, drp_ff, lcnt_ff;
   logic            lact_ff;
   record_type      lfirst_ff, llast_ff;
   opcode_type      op_ff;
   record_type      inrec_ff;
   logic            incrit_ff;
   logic [31:0]     qid_ff;
   logic [FillW-1:0] idx_ff;     // logical index being scanned or moved
   logic            status_ff;
   record_type      orec_ff;

   // ram ports
   logic            wr_en;
   logic [PtrW-1:0] wr_addr, rd_addr;
   record_type      wr_data, rd_data;

   elr_ram #(.Width(RecW), .Depth(Capacity)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // request field decode
   logic [7:0]  req_n_raw;
   logic [1:0]  req_n;
   logic [63:0] req_args;
   always_comb begin
      req_n_raw = req_tdata[114:107];
      req_n     = (req_n_raw >= 8'd2) ? 2'd2 : req_n_raw[1:0];
      req_args  = 64'd0;
      if (req_tdata[179]) begin
         if (req_n >= 2'd1) req_args[31:0]  = req_tdata[146:115];
         if (req_n >= 2'd2) req_args[63:32] = req_tdata[178:147];
      end
   end

   function automatic logic [PtrW-1:0] slot(input logic [PtrW-1:0] h,
                                            input logic [FillW-1:0] l);
      logic [FillW:0] s;
      s = {1'b0, {(FillW - PtrW){1'b0}}, h} + {1'b0, l};
      slot = s[PtrW-1:0];
   endfunction

   // ram addressing: read at the index, write two slots behind
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = slot(head_ff, fill_ff);
      wr_data = inrec_ff;
      rd_addr = slot(head_ff, idx_ff);
      case (state_ff)
         ST_MOVE: begin
            wr_en   = 1'b1;
            wr_addr = slot(head_ff, idx_ff - FillW'(2));
            wr_data = rd_data;
         end
         ST_WRITE: wr_en = 1'b1;
         default: ;
      endcase
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         crit_code_ff <= 8'd3;
         head_ff      <= '0;
         fill_ff      <= '0;
         pub_ff       <= '0;
         con_ff       <= '0;
         ovf_ff       <= '0;
         drp_ff       <= '0;
         lcnt_ff      <= '0;
         lact_ff      <= 1'b0;
         lfirst_ff    <= '0;
         llast_ff     <= '0;
      end else begin
         if (csr_wr_en) crit_code_ff <= csr_wr_data;
         unique case (state_ff)
            ST_IDLE: if (req_tvalid) begin
               op_ff     <= opcode_type'(req_tdata[2:0]);
               inrec_ff  <= '{args: req_args, nargs: req_n, sev: req_tdata[106:99],
                              ident: req_tdata[98:67], time_stamp: req_tdata[66:3]};
               qid_ff    <= req_tdata[98:67];
               status_ff <= 1'b0;
               orec_ff   <= '0;
               idx_ff    <= '0;
               state_ff  <= ST_EXEC;
            end
            ST_EXEC: begin
               incrit_ff <= (inrec_ff.sev == crit_code_ff);
               state_ff  <= ST_RESP;
               unique case (op_ff)
                  OP_REPORT: begin
                     if (inrec_ff.sev == crit_code_ff) begin
                        if (!lact_ff) lfirst_ff <= inrec_ff;
                        lact_ff  <= 1'b1;
                        llast_ff <= inrec_ff;
                        lcnt_ff  <= sat_inc(lcnt_ff);
                     end
                     if (fill_ff == FillW'(Capacity)) begin
                        ovf_ff   <= sat_inc(ovf_ff);
                        state_ff <= ST_SCAN;
                     end else begin
                        state_ff <= ST_WRITE;
                     end
                  end
                  OP_POP: begin
                     if (fill_ff == '0) status_ff <= 1'b1;
                     else state_ff <= ST_POPRD;
                  end
                  OP_CLR_LAT: if (lact_ff) begin
                     if (qid_ff != 32'd0 && llast_ff.ident != qid_ff) begin
                        status_ff <= 1'b1;
                     end else begin
                        lact_ff <= 1'b0; lfirst_ff <= '0; llast_ff <= '0;
                        lcnt_ff <= '0;
                     end
                  end
                  OP_STATS: ;
                  OP_FIRST, OP_LAST: begin
                     status_ff <= !lact_ff;
                     orec_ff   <= (op_ff == OP_FIRST) ? lfirst_ff : llast_ff;
                  end
                  OP_CLR_ALL: begin
                     head_ff <= '0; fill_ff <= '0;
                     pub_ff <= '0; con_ff <= '0; ovf_ff <= '0; drp_ff <= '0;
                     lact_ff <= 1'b0; lfirst_ff <= '0; llast_ff <= '0;
                     lcnt_ff <= '0;
                  end
                  default: status_ff <= 1'b1;
               endcase
            end
            // rd_data holds slot(idx_ff - 1) from the previous cycle
            ST_SCAN: begin
               idx_ff <= idx_ff + FillW'(1);
               if (idx_ff != '0 && rd_data.sev != crit_code_ff) begin
                  // newest record evicted: nothing to move down
                  if (idx_ff == fill_ff) begin
                     fill_ff  <= fill_ff - FillW'(1);
                     state_ff <= ST_WRITE;
                  end else begin
                     state_ff <= ST_MOVE;
                  end
               end else if (idx_ff == fill_ff) begin
                  if (!incrit_ff) begin
                     drp_ff    <= sat_inc(drp_ff);
                     status_ff <= 1'b1;
                     state_ff  <= ST_RESP;
                  end else begin
                     head_ff  <= head_ff + PtrW'(1);
                     fill_ff  <= fill_ff - FillW'(1);
                     state_ff <= ST_WRITE;
                  end
               end
            end
            // rd_data from slot(idx-1) goes to slot(idx-2)
            ST_MOVE: begin
               idx_ff <= idx_ff + FillW'(1);
               if (idx_ff == fill_ff) begin
                  fill_ff  <= fill_ff - FillW'(1);
                  state_ff <= ST_WRITE;
               end
            end
            ST_POPRD: if (idx_ff == '0) begin
               idx_ff <= FillW'(1);
            end else begin
               orec_ff  <= rd_data;
               head_ff  <= head_ff + PtrW'(1);
               fill_ff  <= fill_ff - FillW'(1);
               con_ff   <= sat_inc(con_ff);
               state_ff <= ST_RESP;
            end
            ST_WRITE: begin
               fill_ff  <= fill_ff + FillW'(1);
               pub_ff   <= sat_inc(pub_ff);
               state_ff <= ST_RESP;
            end
            ST_RESP: if (rsp_tready) state_ff <= ST_IDLE;
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_RESP);
   assign rsp_tdata  = {5'd0, lcnt_ff, 8'(fill_ff), drp_ff, ovf_ff, con_ff, pub_ff,
                        orec_ff.args, orec_ff.nargs, orec_ff.sev, orec_ff.ident,
                        orec_ff.time_stamp, status_ff};

   // checks
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FillW'(Capacity)) else $error("fill level beyond capacity");
   a_no_both: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("accepting while result pending");
   a_move_wr: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MOVE |-> wr_en) else $error("move without write");

endmodule
